// ===== sv/rsp_packet_deframer_macros.svh =====
// Assertion macros for the serial debug packet deframer.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef RSP_PACKET_DEFRAMER_MACROS_SVH
`define RSP_PACKET_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds in this cycle -> consequent holds in the same cycle
`define RSP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsp deframer assertion failed");

// antecedent holds in this cycle -> consequent holds in the next cycle
`define RSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsp deframer assertion failed");

`else

`define RSP_ASSERT_SAME(lbl, ante, cons)
`define RSP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/rsp_dfr_pkg.sv =====
// Shared types and constants for the serial debug packet deframer.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package rsp_dfr_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [9:0] count_t;
    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAYLOAD = 2'd0;
    localparam kind_t KIND_ACK     = 2'd1;
    localparam kind_t KIND_NACK    = 2'd2;

    localparam byte_t START_MARK = 8'h24;  // '$'
    localparam byte_t END_MARK   = 8'h23;  // '#'
    localparam byte_t ACK_CHAR   = 8'h2B;  // '+'
    localparam byte_t NACK_CHAR  = 8'h2D;  // '-'

    localparam count_t LIMIT_RESET = 10'd800;

endpackage

// ===== sv/rsp_dfr_ifs.sv =====
// Valid/ready channel interfaces for the deframer: received bytes, results, config.
// Depends on rsp_dfr_pkg.
`timescale 1ns / 1ps

interface rsp_dfr_rx_if;
    logic                 valid;
    logic                 ready;
    rsp_dfr_pkg::byte_t   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rsp_dfr_res_if;
    logic                 valid;
    logic                 ready;
    rsp_dfr_pkg::kind_t   kind;
    rsp_dfr_pkg::byte_t   payload_byte;
    rsp_dfr_pkg::byte_t   reply_char;
    rsp_dfr_pkg::count_t  payload_length;
    rsp_dfr_pkg::byte_t   computed_sum;
    rsp_dfr_pkg::byte_t   sent_sum;

    modport source (output valid, output kind, output payload_byte, output reply_char,
                    output payload_length, output computed_sum, output sent_sum,
                    input ready);
    modport sink   (input valid, input kind, input payload_byte, input reply_char,
                    input payload_length, input computed_sum, input sent_sum,
                    output ready);
endinterface

interface rsp_dfr_cfg_if;
    logic                 valid;
    logic                 ready;
    rsp_dfr_pkg::count_t  max_payload;

    modport source (output valid, output max_payload, input ready);
    modport sink   (input valid, input max_payload, output ready);
endinterface

// ===== sv/rsp_packet_deframer.sv =====
// Serial debug packet deframer: '$' payload '#' hh framing with mod-256 checksum.
// Depends on rsp_dfr_pkg, rsp_dfr_ifs and rsp_packet_deframer_macros.svh.
//
// Usage:
//   rx  : one received byte per item. Bytes before '$' are dropped.
//   res : one item per payload byte (kind 0), and one verdict item (ack '+'
//         or nack '-') after the second checksum digit, carrying the payload
//         length, computed sum and sent sum. '#' and digits give no item.
//   cfg : writes max_payload (always ready); a payload of that many bytes or
//         more is rejected and the excess bytes are suppressed.
// Timing: a byte is taken into an input register and decoded against the
//   packet state there. Its result is written to the output register as the
//   byte leaves the input register and is offered on res from there. One byte
//   per cycle is sustained unless res stalls; the state update is the only loop.
// Reset: packet state clears to waiting-for-'$', max_payload returns to 800,
//   both pipeline registers empty.
// Stall: while res.ready is low and a result is held, the input register
//   holds its byte; rx.ready drops once that register is also occupied.
`timescale 1ns / 1ps
`include "rsp_packet_deframer_macros.svh"

module rsp_packet_deframer
(
    input  logic                 clk,
    input  logic                 rst_n,
    rsp_dfr_rx_if.sink           rx,
    rsp_dfr_res_if.source        res,
    rsp_dfr_cfg_if.sink          cfg
);

    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_LO   = 2'd3;

    // {valid, value}
    function automatic logic [4:0] hex_decode(input rsp_dfr_pkg::byte_t c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // config
    rsp_dfr_pkg::count_t max_payload_reg;

    // input stage
    logic                stage_vld_reg;
    rsp_dfr_pkg::byte_t  stage_byte_reg;

    // packet state
    logic [1:0]          phase_reg, phase_next;
    rsp_dfr_pkg::byte_t  sum_reg, sum_next;
    rsp_dfr_pkg::count_t count_reg, count_next;
    logic [3:0]          hi_nib_reg, hi_nib_next;
    logic                bad_reg, bad_next;

    // output register
    logic                out_vld_reg;
    rsp_dfr_pkg::kind_t  out_kind_reg;
    rsp_dfr_pkg::byte_t  out_payload_reg;
    rsp_dfr_pkg::byte_t  out_reply_reg;
    rsp_dfr_pkg::count_t out_len_reg;
    rsp_dfr_pkg::byte_t  out_csum_reg;
    rsp_dfr_pkg::byte_t  out_ssum_reg;

    logic                adv;
    logic                stage_go;
    logic                rx_take;
    logic                has_res;
    rsp_dfr_pkg::kind_t  res_kind;
    rsp_dfr_pkg::byte_t  res_payload;
    rsp_dfr_pkg::byte_t  res_reply;
    rsp_dfr_pkg::count_t res_len;
    rsp_dfr_pkg::byte_t  res_csum;
    rsp_dfr_pkg::byte_t  res_ssum;
    logic [4:0]          hex;
    logic                below_limit;
    logic                bad_lo;
    rsp_dfr_pkg::byte_t  sent;
    logic                accept;

    assign adv      = !out_vld_reg || res.ready;
    assign stage_go = stage_vld_reg && adv;
    assign rx.ready = !stage_vld_reg || adv;
    assign rx_take  = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    assign hex         = hex_decode(stage_byte_reg);
    assign below_limit = count_reg < max_payload_reg;
    assign bad_lo      = bad_reg || !hex[4];
    assign sent        = {hi_nib_reg, hex[3:0]};
    assign accept      = !bad_lo && below_limit && (sent == sum_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        hi_nib_next = hi_nib_reg;
        bad_next    = bad_reg;
        has_res     = 1'b0;
        res_kind    = rsp_dfr_pkg::KIND_PAYLOAD;
        res_payload = '0;
        res_reply   = '0;
        res_len     = '0;
        res_csum    = '0;
        res_ssum    = '0;
        case (phase_reg)
            PH_WAIT:
            begin
                if (stage_byte_reg == rsp_dfr_pkg::START_MARK)
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (stage_byte_reg == rsp_dfr_pkg::END_MARK)
                    phase_next = PH_HI;
                else if (below_limit)
                begin
                    sum_next    = sum_reg + stage_byte_reg;
                    count_next  = count_reg + 10'd1;
                    has_res     = 1'b1;
                    res_payload = stage_byte_reg;
                end
                else
                    bad_next = 1'b1;
            end
            PH_HI:
            begin
                bad_next    = bad_reg || !hex[4];
                hi_nib_next = hex[3:0];
                phase_next  = PH_LO;
            end
            PH_LO:
            begin
                has_res     = 1'b1;
                res_kind    = accept ? rsp_dfr_pkg::KIND_ACK : rsp_dfr_pkg::KIND_NACK;
                res_reply   = accept ? rsp_dfr_pkg::ACK_CHAR : rsp_dfr_pkg::NACK_CHAR;
                res_len     = count_reg;
                res_csum    = sum_reg;
                res_ssum    = sent;
                phase_next  = PH_WAIT;
                sum_next    = '0;
                count_next  = '0;
                hi_nib_next = '0;
                bad_next    = 1'b0;
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= rsp_dfr_pkg::LIMIT_RESET;
            stage_vld_reg   <= 1'b0;
            phase_reg       <= PH_WAIT;
            sum_reg         <= '0;
            count_reg       <= '0;
            hi_nib_reg      <= '0;
            bad_reg         <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                max_payload_reg <= cfg.max_payload;
            if (rx.ready)
                stage_vld_reg <= rx.valid;
            if (stage_go)
            begin
                phase_reg  <= phase_next;
                sum_reg    <= sum_next;
                count_reg  <= count_next;
                hi_nib_reg <= hi_nib_next;
                bad_reg    <= bad_next;
            end
            if (adv)
                out_vld_reg <= stage_go && has_res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            stage_byte_reg <= rx.rx_byte;
        if (stage_go && has_res)
        begin
            out_kind_reg    <= res_kind;
            out_payload_reg <= res_payload;
            out_reply_reg   <= res_reply;
            out_len_reg     <= res_len;
            out_csum_reg    <= res_csum;
            out_ssum_reg    <= res_ssum;
        end
    end

    assign res.valid          = out_vld_reg;
    assign res.kind           = out_kind_reg;
    assign res.payload_byte   = out_payload_reg;
    assign res.reply_char     = out_reply_reg;
    assign res.payload_length = out_len_reg;
    assign res.computed_sum   = out_csum_reg;
    assign res.sent_sum       = out_ssum_reg;

    // a verdict always leaves the packet state cleared
    `RSP_ASSERT_NEXT(a_verdict_clears, stage_go && phase_reg == PH_LO,
                     phase_reg == PH_WAIT && count_reg == '0 && sum_reg == '0 && !bad_reg)
    // an ack carries matching checksums
    `RSP_ASSERT_SAME(a_ack_sums_match, res.valid && res.kind == rsp_dfr_pkg::KIND_ACK,
                     res.sent_sum == res.computed_sum)
    // a byte blocked by a held result stays in the input register
    `RSP_ASSERT_NEXT(a_stage_holds, stage_vld_reg && !adv, stage_vld_reg && $stable(stage_byte_reg))

endmodule
